// ===== design/hsal_pkg.sv =====
// Shared types and constants for the Hermite spline arc length block.
package hsal_pkg;

    localparam int IN_W     = 32;
    localparam int LEN_W    = 32;
    localparam int COORDS   = 3;
    localparam int TERMS    = 4;
    localparam int FIELDS   = 12;
    localparam int IN_BUS_W = FIELDS * IN_W;
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = 33;
    localparam int STEPS_W  = 8;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd15;
    localparam logic [1:0]         LAST_TERM   = 2'(TERMS - 1);
    localparam logic [1:0]         LAST_AXIS   = 2'(COORDS - 1);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_N2,
        OP_N3,
        OP_K2,
        OP_K3,
        OP_K2N,
        OP_K2M,
        OP_KM,
        OP_H3,
        OP_H1,
        OP_DIV,
        OP_CMUL,
        OP_CACC,
        OP_ROUND,
        OP_DIFF,
        OP_SQ,
        OP_SADD,
        OP_SQRT,
        OP_ACCUM,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_N2,
        ST_N3,
        ST_K2,
        ST_K3,
        ST_K2N,
        ST_K2M,
        ST_KM,
        ST_H3,
        ST_H1,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CMUL,
        ST_CACC,
        ST_ROUND,
        ST_DIFF,
        ST_SQ,
        ST_SADD,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_ACCUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] term;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic last_sample;
    } status_t;

endpackage

// ===== design/hsal_div.sv =====
// Restoring divider producing one rounded basis weight, one quotient bit per cycle.
module hsal_div #(
    parameter int DEN_W     = 27,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DEN_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    input  logic                       neg,
    output logic                       done,
    output logic signed [FRAC_BITS+1:0] quot
);

    localparam int Q_W   = FRAC_BITS + 1;
    localparam int DVD_W = DEN_W + Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   lo_reg;
    logic [Q_W-1:0]   quo_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVD_W-1:0] dvd;
    logic [DEN_W:0]   trial;
    logic             ge;

    // (num << F) + den/2; quotient is at most 2^F so the top part starts below den
    assign dvd   = DVD_W'({num, FRAC_BITS'(0)}) + DVD_W'(den >> 1);
    assign trial = {rem_reg, lo_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= dvd[DVD_W-1:Q_W];
            lo_reg  <= dvd[Q_W-1:0];
            den_reg <= den;
            neg_reg <= neg;
        end else if (busy_reg) begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            lo_reg  <= lo_reg << 1;
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ===== design/hsal_sqrt.sv =====
// Digit-by-digit square root of a 64-bit value, rounded to nearest, two bits per cycle.
module hsal_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [hsal_pkg::SQ_W-1:0]        radicand,
    output logic                             done,
    output logic [hsal_pkg::ROOT_W-1:0]      root
);

    localparam int HALF_W = hsal_pkg::SQ_W / 2;
    localparam int REM_W  = HALF_W + 2;
    localparam int CNT_W  = $clog2(HALF_W + 1);

    logic [hsal_pkg::SQ_W-1:0] rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [HALF_W-1:0]         root_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign rem_sh = {rem_reg, rad_reg[hsal_pkg::SQ_W-1 -: 2]};
    assign trial  = (REM_W + 2)'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(HALF_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[HALF_W-2:0], ge};
        end
    end

    // round up when the remainder exceeds the floor root
    assign done = done_reg;
    assign root = hsal_pkg::ROOT_W'(root_reg) +
                  hsal_pkg::ROOT_W'(REM_W'(root_reg) < rem_reg);

endmodule

// ===== design/hsal_ctrl.sv =====
// Sequencer that walks samples, weights, coordinates and chords for one segment.
module hsal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_free,
    input  hsal_pkg::status_t status,
    output hsal_pkg::cmd_t    cmd,
    output logic              idle
);

    hsal_pkg::state_t state_reg, state_next;
    logic [1:0]       term_reg, term_next;
    logic [1:0]       axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= hsal_pkg::ST_IDLE;
            term_reg  <= '0;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        axis_next  = axis_reg;
        case (state_reg)
            hsal_pkg::ST_IDLE:   if (in_valid) state_next = hsal_pkg::ST_N2;
            hsal_pkg::ST_N2:     state_next = hsal_pkg::ST_N3;
            hsal_pkg::ST_N3:     state_next = hsal_pkg::ST_K2;
            hsal_pkg::ST_K2:     state_next = hsal_pkg::ST_K3;
            hsal_pkg::ST_K3:     state_next = hsal_pkg::ST_K2N;
            hsal_pkg::ST_K2N:    state_next = hsal_pkg::ST_K2M;
            hsal_pkg::ST_K2M:    state_next = hsal_pkg::ST_KM;
            hsal_pkg::ST_KM:     state_next = hsal_pkg::ST_H3;
            hsal_pkg::ST_H3:     state_next = hsal_pkg::ST_H1;
            hsal_pkg::ST_H1:
            begin
                state_next = hsal_pkg::ST_DIV_GO;
                term_next  = '0;
            end
            hsal_pkg::ST_DIV_GO: state_next = hsal_pkg::ST_DIV_WAIT;
            hsal_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done) begin
                    if (term_reg == hsal_pkg::LAST_TERM) begin
                        state_next = hsal_pkg::ST_CMUL;
                        term_next  = '0;
                        axis_next  = '0;
                    end else begin
                        state_next = hsal_pkg::ST_DIV_GO;
                        term_next  = term_reg + 2'd1;
                    end
                end
            end
            hsal_pkg::ST_CMUL:   state_next = hsal_pkg::ST_CACC;
            hsal_pkg::ST_CACC:
            begin
                if (term_reg == hsal_pkg::LAST_TERM) begin
                    state_next = hsal_pkg::ST_ROUND;
                    term_next  = '0;
                end else begin
                    state_next = hsal_pkg::ST_CMUL;
                    term_next  = term_reg + 2'd1;
                end
            end
            hsal_pkg::ST_ROUND:
            begin
                if (axis_reg == hsal_pkg::LAST_AXIS) begin
                    state_next = hsal_pkg::ST_DIFF;
                    axis_next  = '0;
                end else begin
                    state_next = hsal_pkg::ST_CMUL;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            hsal_pkg::ST_DIFF:   state_next = hsal_pkg::ST_SQ;
            hsal_pkg::ST_SQ:     state_next = hsal_pkg::ST_SADD;
            hsal_pkg::ST_SADD:
            begin
                if (axis_reg == hsal_pkg::LAST_AXIS) begin
                    state_next = hsal_pkg::ST_SQRT_GO;
                    axis_next  = '0;
                end else begin
                    state_next = hsal_pkg::ST_DIFF;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            hsal_pkg::ST_SQRT_GO: state_next = hsal_pkg::ST_SQRT_WAIT;
            hsal_pkg::ST_SQRT_WAIT:
                if (status.sqrt_done) state_next = hsal_pkg::ST_ACCUM;
            hsal_pkg::ST_ACCUM:
                state_next = status.last_sample ? hsal_pkg::ST_DONE : hsal_pkg::ST_K2;
            hsal_pkg::ST_DONE:   if (out_free) state_next = hsal_pkg::ST_IDLE;
            default:             state_next = hsal_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.term = term_reg;
        cmd.axis = axis_reg;
        idle     = 1'b0;
        case (state_reg)
            hsal_pkg::ST_IDLE:
            begin
                idle   = 1'b1;
                cmd.op = in_valid ? hsal_pkg::OP_LOAD : hsal_pkg::OP_NONE;
            end
            hsal_pkg::ST_N2:      cmd.op = hsal_pkg::OP_N2;
            hsal_pkg::ST_N3:      cmd.op = hsal_pkg::OP_N3;
            hsal_pkg::ST_K2:      cmd.op = hsal_pkg::OP_K2;
            hsal_pkg::ST_K3:      cmd.op = hsal_pkg::OP_K3;
            hsal_pkg::ST_K2N:     cmd.op = hsal_pkg::OP_K2N;
            hsal_pkg::ST_K2M:     cmd.op = hsal_pkg::OP_K2M;
            hsal_pkg::ST_KM:      cmd.op = hsal_pkg::OP_KM;
            hsal_pkg::ST_H3:      cmd.op = hsal_pkg::OP_H3;
            hsal_pkg::ST_H1:      cmd.op = hsal_pkg::OP_H1;
            hsal_pkg::ST_DIV_GO:  cmd.op = hsal_pkg::OP_DIV;
            hsal_pkg::ST_CMUL:    cmd.op = hsal_pkg::OP_CMUL;
            hsal_pkg::ST_CACC:    cmd.op = hsal_pkg::OP_CACC;
            hsal_pkg::ST_ROUND:   cmd.op = hsal_pkg::OP_ROUND;
            hsal_pkg::ST_DIFF:    cmd.op = hsal_pkg::OP_DIFF;
            hsal_pkg::ST_SQ:      cmd.op = hsal_pkg::OP_SQ;
            hsal_pkg::ST_SADD:    cmd.op = hsal_pkg::OP_SADD;
            hsal_pkg::ST_SQRT_GO: cmd.op = hsal_pkg::OP_SQRT;
            hsal_pkg::ST_ACCUM:   cmd.op = hsal_pkg::OP_ACCUM;
            hsal_pkg::ST_DONE:
                cmd.op = out_free ? hsal_pkg::OP_OUT : hsal_pkg::OP_NONE;
            default:              cmd.op = hsal_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== design/hsal_datapath.sv =====
// Datapath: basis polynomials, weights, sample points, chord lengths and running total.
module hsal_datapath #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_STEPS = 255
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hsal_pkg::cmd_t                      cmd,
    input  logic [hsal_pkg::STEPS_W-1:0]        steps,
    input  logic [hsal_pkg::IN_BUS_W-1:0]       in_data,
    output hsal_pkg::status_t                   status,
    output logic [hsal_pkg::LEN_W-1:0]          total
);

    localparam int NW     = $clog2(MAX_STEPS + 2);
    localparam int DW     = 3 * NW;
    localparam int HW     = DW + 2;
    localparam int WGT_W  = FRAC_BITS + 2;
    localparam int MUL_A  = (2 * NW + 1 > WGT_W) ? 2 * NW + 1 : WGT_W;
    localparam int MUL_W  = (MUL_A > hsal_pkg::IN_W + 1) ? MUL_A : hsal_pkg::IN_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = hsal_pkg::IN_W + WGT_W + 2;
    localparam int CUR_W  = ACC_W - FRAC_BITS + 1;
    localparam int DIF_W  = CUR_W + 1;
    localparam int SUM_W  = hsal_pkg::SQ_W + 2;
    localparam int IN_W   = hsal_pkg::IN_W;
    localparam int LEN_W  = hsal_pkg::LEN_W;

    logic signed [IN_W-1:0]   c_reg [hsal_pkg::TERMS][hsal_pkg::COORDS];
    logic [NW-1:0]            n_reg;
    logic [NW-1:0]            k_reg;
    logic [2*NW-1:0]          t_reg;
    logic [DW-1:0]            u_reg;
    logic [DW-1:0]            v_reg;
    logic [DW-1:0]            n3_reg;
    logic signed [HW-1:0]     h_reg [hsal_pkg::TERMS];
    logic signed [WGT_W-1:0]  w_reg [hsal_pkg::TERMS];
    logic [1:0]               wsel_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [CUR_W-1:0]  cur_reg [hsal_pkg::COORDS];
    logic signed [CUR_W-1:0]  last_reg [hsal_pkg::COORDS];
    logic [LEN_W-1:0]         dmag_reg;
    logic                     big_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [LEN_W-1:0]         total_reg;

    logic [NW-1:0]            m;
    logic [NW-1:0]            n_calc;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DW+3:0]     u_s, v_s, n3_s, h1_full, h2_full;
    logic signed [HW-1:0]     h_sel;
    logic [DW-1:0]            h_mag;
    logic                     div_done;
    logic signed [WGT_W-1:0]  quot;
    logic [ACC_W-1:0]         acc_mag;
    logic [ACC_W:0]           acc_half;
    logic [CUR_W-1:0]         r_mag;
    logic signed [CUR_W-1:0]  cur_rnd;
    logic signed [DIF_W-1:0]  diff;
    logic [DIF_W-1:0]         dabs;
    logic                     sqrt_done;
    logic [hsal_pkg::ROOT_W-1:0] root;
    logic [hsal_pkg::ROOT_W-1:0] len;
    logic [LEN_W+1:0]         tsum;

    assign m      = n_reg - k_reg;
    assign n_calc = (int'(steps) > MAX_STEPS) ? NW'(MAX_STEPS + 1) : NW'(steps) + NW'(1);

    // single shared multiplier, operands picked by the command
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            hsal_pkg::OP_N2:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'(n_reg);
            end
            hsal_pkg::OP_N3:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(n_reg);
            end
            hsal_pkg::OP_K2:
            begin
                mul_a = MUL_W'(k_reg);
                mul_b = MUL_W'(k_reg);
            end
            hsal_pkg::OP_K3:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(k_reg);
            end
            hsal_pkg::OP_K2N:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(n_reg);
            end
            hsal_pkg::OP_K2M, hsal_pkg::OP_H3:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(m);
            end
            hsal_pkg::OP_KM:
            begin
                mul_a = MUL_W'(k_reg);
                mul_b = MUL_W'(m);
            end
            hsal_pkg::OP_CMUL:
            begin
                mul_a = MUL_W'(c_reg[cmd.term][cmd.axis]);
                mul_b = MUL_W'(w_reg[cmd.term]);
            end
            hsal_pkg::OP_SQ:
            begin
                mul_a = MUL_W'(dmag_reg);
                mul_b = MUL_W'(dmag_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // h1 = 2k^3 - 3k^2 n + n^3, h2 = n^3 - h1
    assign u_s     = $signed({4'b0, u_reg});
    assign v_s     = $signed({4'b0, v_reg});
    assign n3_s    = $signed({4'b0, n3_reg});
    assign h1_full = (u_s <<< 1) - v_s - (v_s <<< 1) + n3_s;
    assign h2_full = v_s + (v_s <<< 1) - (u_s <<< 1);

    assign h_sel = h_reg[cmd.term];
    assign h_mag = DW'(h_sel[HW-1] ? -h_sel : h_sel);

    // round to nearest, ties away from zero
    assign acc_mag  = ACC_W'(acc_reg[ACC_W-1] ? -acc_reg : acc_reg);
    assign acc_half = {1'b0, acc_mag} + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
    assign r_mag    = CUR_W'(acc_half >> FRAC_BITS);
    assign cur_rnd  = acc_reg[ACC_W-1] ? -$signed(r_mag) : $signed(r_mag);

    assign diff = DIF_W'(cur_reg[cmd.axis]) - DIF_W'(last_reg[cmd.axis]);
    assign dabs = DIF_W'(diff[DIF_W-1] ? -diff : diff);

    assign len  = (big_reg || (|sum_reg[SUM_W-1:hsal_pkg::SQ_W]))
                  ? hsal_pkg::ROOT_W'(1) << LEN_W : root;
    assign tsum = (LEN_W + 2)'(total_reg) + (LEN_W + 2)'(len);

    always_ff @(posedge clk) begin
        case (cmd.op)
            hsal_pkg::OP_LOAD:
            begin
                for (int j = 0; j < hsal_pkg::TERMS; j++) begin
                    for (int i = 0; i < hsal_pkg::COORDS; i++) begin
                        c_reg[j][i] <= in_data[(j * hsal_pkg::COORDS + i) * IN_W +: IN_W];
                    end
                end
                for (int i = 0; i < hsal_pkg::COORDS; i++) begin
                    last_reg[i] <= CUR_W'($signed(in_data[i * IN_W +: IN_W]));
                end
                n_reg     <= n_calc;
                k_reg     <= NW'(1);
                total_reg <= '0;
            end
            hsal_pkg::OP_N2, hsal_pkg::OP_K2, hsal_pkg::OP_KM: t_reg <= (2 * NW)'(mul_p);
            hsal_pkg::OP_N3:  n3_reg   <= DW'(mul_p);
            hsal_pkg::OP_K3:  u_reg    <= DW'(mul_p);
            hsal_pkg::OP_K2N: v_reg    <= DW'(mul_p);
            hsal_pkg::OP_K2M: h_reg[3] <= -HW'(mul_p);
            hsal_pkg::OP_H3:  h_reg[2] <= HW'(mul_p);
            hsal_pkg::OP_H1:
            begin
                h_reg[0] <= HW'(h1_full);
                h_reg[1] <= HW'(h2_full);
            end
            hsal_pkg::OP_DIV: wsel_reg <= cmd.term;
            hsal_pkg::OP_CMUL, hsal_pkg::OP_SQ: prod_reg <= mul_p;
            hsal_pkg::OP_CACC:
                acc_reg <= ((cmd.term == '0) ? '0 : acc_reg) + ACC_W'(prod_reg);
            hsal_pkg::OP_ROUND: cur_reg[cmd.axis] <= cur_rnd;
            hsal_pkg::OP_DIFF:
            begin
                dmag_reg <= dabs[LEN_W-1:0];
                big_reg  <= ((cmd.axis == '0) ? 1'b0 : big_reg) | (|dabs[DIF_W-1:LEN_W]);
            end
            hsal_pkg::OP_SADD:
                sum_reg <= ((cmd.axis == '0) ? '0 : sum_reg) +
                           SUM_W'(prod_reg[hsal_pkg::SQ_W-1:0]);
            hsal_pkg::OP_ACCUM:
            begin
                total_reg <= (|tsum[LEN_W+1:LEN_W]) ? '1 : tsum[LEN_W-1:0];
                for (int i = 0; i < hsal_pkg::COORDS; i++) begin
                    last_reg[i] <= cur_reg[i];
                end
                k_reg <= k_reg + NW'(1);
            end
            default:
            begin
            end
        endcase
        if (div_done) begin
            w_reg[wsel_reg] <= quot;
        end
    end

    hsal_div #(
        .DEN_W     (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == hsal_pkg::OP_DIV),
        .num   (h_mag),
        .den   (n3_reg),
        .neg   (h_sel[HW-1]),
        .done  (div_done),
        .quot  (quot)
    );

    hsal_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == hsal_pkg::OP_SQRT),
        .radicand (sum_reg[hsal_pkg::SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    assign status.div_done    = div_done;
    assign status.sqrt_done   = sqrt_done;
    assign status.last_sample = (k_reg == n_reg);
    assign total              = total_reg;

endmodule

// ===== design/hermite_spline_arc_length_top.sv =====
// Top level of the Hermite spline chord-length estimator.
//
// Usage:
//  - s_axis: one beat carries one cubic Hermite segment (P0, P1, D0, D1, 3-D,
//    signed fixed point). tready is high only while the sequencer is idle.
//  - m_axis: one beat per segment with the summed chord length, unsigned,
//    saturating at all ones. The result sits in an output register, so a new
//    segment is taken while the previous result still waits for tready.
//  - cfg_we/cfg_wdata: writes segment_steps (chords minus one, clamped to
//    MAX_STEPS); write only while no segment is in flight.
// Operation (n = chords):
//  - per sample the shared multiplier sequences polynomials, coordinates and
//    squares, the bit-serial divider makes four weights, and the square root
//    unit takes the root of one chord.
//  - a segment walks n samples (16 chords by default); one segment in work at
//    a time.
// Reset: sequencer idle, output empty, segment_steps back to 15.
// A stalled m_axis holds the result; the next result waits in the sequencer.
module hermite_spline_arc_length_top #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_STEPS = 255
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fields from bit 0: start_x, start_y, start_z, end_x, end_y, end_z,
    // start_tangent_x/y/z, end_tangent_x/y/z (32 bits each)
    input  logic [383:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fields from bit 0: arc_length (32 bits)
    output logic [31:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);

    logic [hsal_pkg::STEPS_W-1:0] steps_reg;
    logic                         out_valid_reg;
    logic [hsal_pkg::LEN_W-1:0]   out_data_reg;

    hsal_pkg::cmd_t               cmd;
    hsal_pkg::status_t            status;
    logic                         idle;
    logic                         out_free;
    logic [hsal_pkg::LEN_W-1:0]   total;

    // output slot is free if empty or being drained this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            steps_reg     <= hsal_pkg::STEPS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                steps_reg <= cfg_wdata;
            end
            if (cmd.op == hsal_pkg::OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.op == hsal_pkg::OP_OUT) begin
            out_data_reg <= total;
        end
    end

    hsal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle)
    );

    hsal_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .steps   (steps_reg),
        .in_data (s_axis_tdata),
        .status  (status),
        .total   (total)
    );

    assign s_axis_tready = idle;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == hsal_pkg::OP_OUT) |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten while stalled");

    // every accepted beat loads the datapath
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (cmd.op == hsal_pkg::OP_LOAD))
        else $error("input beat accepted without load");

    // busy right after an accepted beat
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after accept");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the Hermite spline arc length block: directed and random segments.
module testbench;

    localparam int FRAC    = 16;
    localparam int MAX_N   = 255;
    localparam int STALL_LIMIT = 200000;   // longest segment has 256 chords
    localparam int TAIL    = 50;

    typedef logic signed [hsal_pkg::IN_W-1:0] segment_t [hsal_pkg::FIELDS];

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [hsal_pkg::IN_BUS_W-1:0] s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [hsal_pkg::LEN_W-1:0]    m_axis_tdata;
    logic                          cfg_we;
    logic [hsal_pkg::STEPS_W-1:0]  cfg_wdata;

    // lengths still owed by the block, oldest first
    logic [hsal_pkg::LEN_W-1:0] arc_len_due [$];
    logic [hsal_pkg::STEPS_W-1:0] steps_shadow;
    int mismatches;
    int send_gap_pct;
    int recv_stall_pct;
    int quiet_cycles;

    hermite_spline_arc_length_top #(
        .FRAC_BITS(FRAC),
        .MAX_STEPS(MAX_N)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- predictor ----------------

    // basis weight h/den with FRAC fraction bits, ties away from zero
    function automatic longint basis_weight(longint h, longint den);
        longint mag;
        longint w;
        mag = (h < 0) ? -h : h;
        w = ((mag << FRAC) + den / 2) / den;
        return (h < 0) ? -w : w;
    endfunction

    // drop FRAC fraction bits, round half away from zero
    function automatic longint round_frac(longint acc);
        longint mag;
        longint r;
        mag = (acc < 0) ? -acc : acc;
        r = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
        return (acc < 0) ? -r : r;
    endfunction

    // integer square root, rounded to nearest
    function automatic logic [63:0] nearest_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bt;
        res = '0;
        bt = 64'd1 << 62;
        while (bt > s)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (s >= res + bt)
            begin
                s = s - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        if (s > res)
            res = res + 1;
        return res;
    endfunction

    // one chord; 2^32 stands for "too long"
    function automatic logic [63:0] chord_len(longint a [3], longint b [3]);
        logic [64:0] sum;
        logic [63:0] m;
        longint d;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = b[i] - a[i];
            m = (d < 0) ? -d : d;
            if (m > 64'hFFFF_FFFF)
                return 64'h1_0000_0000;
            sum = sum + m * m;
            if (sum[64])
                return 64'h1_0000_0000;
        end
        return nearest_sqrt(sum[63:0]);
    endfunction

    function automatic logic [hsal_pkg::LEN_W-1:0] predict_arc_len(
        segment_t seg, logic [hsal_pkg::STEPS_W-1:0] st);
        longint n, n3, k, m;
        longint h [4];
        longint w [4];
        longint pt [4][3];
        longint prev [3];
        longint cur [3];
        longint acc;
        logic [63:0] total;
        n = ((st > MAX_N) ? MAX_N : st) + 1;
        n3 = n * n * n;
        total = '0;
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 3; i++)
                pt[j][i] = seg[j * 3 + i];
        for (int i = 0; i < 3; i++)
            prev[i] = pt[0][i];
        for (k = 1; k <= n; k++)
        begin
            m = n - k;
            h[0] = 2 * k * k * k - 3 * k * k * n + n3;
            h[1] = n3 - h[0];
            h[2] = k * m * m;
            h[3] = -(k * k * m);
            for (int j = 0; j < 4; j++)
                w[j] = basis_weight(h[j], n3);
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int j = 0; j < 4; j++)
                    acc = acc + pt[j][i] * w[j];
                cur[i] = round_frac(acc);
            end
            total = total + chord_len(prev, cur);
            if (total > 64'hFFFF_FFFF)
                total = 64'hFFFF_FFFF;
            prev = cur;
        end
        return total[hsal_pkg::LEN_W-1:0];
    endfunction

    // ---------------- result side ----------------

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (arc_len_due.size() == 0)
            begin
                $display("%0t: unexpected arc_length, expected none, actual %h", $time,
                         m_axis_tdata);
                mismatches++;
            end
            else if (m_axis_tdata !== arc_len_due[0])
            begin
                $display("%0t: arc_length mismatch, expected %h, actual %h", $time,
                         arc_len_due[0], m_axis_tdata);
                mismatches++;
                void'(arc_len_due.pop_front());
            end
            else
                void'(arc_len_due.pop_front());
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- shared tasks ----------------

    // called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_segment(segment_t seg);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        for (int i = 0; i < hsal_pkg::FIELDS; i++)
            s_axis_tdata[i * hsal_pkg::IN_W +: hsal_pkg::IN_W] <= seg[i];
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        arc_len_due.push_back(predict_arc_len(seg, steps_shadow));
        @(negedge clk);
    endtask

    // wait for every owed result, then let the sequencer settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (arc_len_due.size() != 0)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);
    endtask

    task automatic set_steps(logic [hsal_pkg::STEPS_W-1:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        steps_shadow = v;
    endtask

    function automatic segment_t fill_segment(logic signed [hsal_pkg::IN_W-1:0] v);
        segment_t seg;
        for (int i = 0; i < hsal_pkg::FIELDS; i++)
            seg[i] = v;
        return seg;
    endfunction

    function automatic segment_t random_segment();
        segment_t seg;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < hsal_pkg::FIELDS; i++)
        begin
            if (kind < 5)        // moderate curves that rarely saturate
                seg[i] = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            else if (kind < 8)   // full range, exercises saturation and every bit
                seg[i] = $urandom;
            else                 // short, mostly straight segments
                seg[i] = (i >= 6) ? 32'sd0 : $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
        end
        return seg;
    endfunction

    // ---------------- tests ----------------

    task automatic test_default_steps;
        segment_t seg;
        // reset value of segment_steps is 15
        send_segment(fill_segment(32'sd0));
        seg = fill_segment(32'sd0);
        seg[3] = 32'sh0003_0000;
        seg[4] = 32'sh0004_0000;
        send_segment(seg);          // straight line of length 5
        send_segment(random_segment());
    endtask

    task automatic test_extremes;
        segment_t seg;
        set_steps(8'd0);
        send_segment(fill_segment(32'sh7FFF_FFFF));
        send_segment(fill_segment(-32'sh8000_0000));
        seg = fill_segment(-32'sh8000_0000);
        for (int i = 3; i < 6; i++)
            seg[i] = 32'sh7FFF_FFFF;  // one chord far beyond 2^32
        send_segment(seg);
        seg = fill_segment(32'sd0);
        seg[0] = 32'sh7FFF_FFFF;
        seg[3] = -32'sh8000_0000;
        send_segment(seg);            // one axis just under the limit
        seg = fill_segment(32'sd0);
        seg[6] = 32'sh7FFF_FFFF;
        seg[9] = -32'sh8000_0000;
        send_segment(seg);            // tangents only, closed loop
        set_steps(8'd1);
        send_segment(seg);
        seg = fill_segment(32'sd1);
        seg[3] = 32'sd2;
        send_segment(seg);            // rounding ties on tiny values
        set_steps(8'd255);            // largest step count
        send_segment(seg);
        seg = fill_segment(32'sd0);
        for (int i = 6; i < hsal_pkg::FIELDS; i++)
            seg[i] = 32'sh4000_0000;
        send_segment(seg);            // large tangents summed over many chords
        set_steps(8'd254);
        send_segment(random_segment());
    endtask

    task automatic test_random_mode(int gap, int stall, int count);
        logic [hsal_pkg::STEPS_W-1:0] step_list [5];
        step_list = '{8'd0, 8'd1, 8'd3, 8'd6, 8'd2};
        drain();
        send_gap_pct = gap;
        recv_stall_pct = stall;
        for (int p = 0; p < 5; p++)
        begin
            set_steps(step_list[p]);
            for (int i = 0; i < count; i++)
                send_segment(random_segment());
        end
    endtask

    task automatic test_pause_until_empty;
        set_steps(8'd4);
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 5; i++)
                send_segment(random_segment());
            drain();                  // sender holds off until nothing is owed
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        quiet_cycles = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        steps_shadow = hsal_pkg::STEPS_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_steps();
        test_extremes();
        test_random_mode(36, 59, 52);
        test_random_mode(59, 36, 52);
        test_pause_until_empty();
        test_random_mode(0, 0, 52);

        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
